// ===== rtl/sifr_pkg.sv =====
// Shared types and constants of the serial image frame receiver.
package sifr_pkg;

    // Sync word: 'B','I','N' in the window (oldest byte highest), then '1'.
    localparam logic [23:0] SYNC_PREFIX = 24'h42494E;
    localparam logic [7:0]  SYNC_LAST   = 8'h31;

    localparam logic [11:0] FB_WIDTH_RESET       = 12'd800;
    localparam logic [11:0] FB_HEIGHT_RESET      = 12'd480;
    localparam logic [15:0] UPSCALE_WIDTH_RESET  = 16'd400;
    localparam logic [15:0] UPSCALE_HEIGHT_RESET = 16'd240;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FB_WIDTH       = 2'd0;
    localparam logic [1:0] REG_FB_HEIGHT      = 2'd1;
    localparam logic [1:0] REG_UPSCALE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_UPSCALE_HEIGHT = 2'd3;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // Result slots of one command, in emission order.
    localparam int SLOT_READY = 0;
    localparam int SLOT_W00   = 1;
    localparam int SLOT_W10   = 2;
    localparam int SLOT_W01   = 3;
    localparam int SLOT_W11   = 4;
    localparam int SLOT_DONE  = 5;
    localparam int NUM_SLOTS  = 6;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_READY = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    // One command handed from the parser to the write sequencer.
    typedef struct packed {
        logic        is_ready;  // header finished, else a pixel
        logic        done;      // frame complete follows
        logic        upscale;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] pix;
    } t_cmd;

endpackage

// ===== rtl/sifr_front.sv =====
// Byte parser: sync hunt, header capture and pixel assembly into commands.
module sifr_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_rx_byte,
    input  logic [15:0]     i_upscale_width,
    input  logic [15:0]     i_upscale_height,
    output logic            o_cmd_push,
    output sifr_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [23:0] r_window,   n_window;
    logic [2:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [31:0] r_fw,       n_fw;
    logic [31:0] r_fh,       n_fh;
    logic        r_upscale,  n_upscale;
    logic [15:0] r_col,      n_col;
    logic [15:0] r_row,      n_row;
    logic [7:0]  r_low,      n_low;
    logic        r_have_low, n_have_low;

    logic [31:0] hdr_lane;
    logic [16:0] col_inc;
    logic [16:0] row_inc;

    assign hdr_lane = {24'd0, i_rx_byte} << {r_hdr_cnt[1:0], 3'b000};
    assign col_inc  = {1'b0, r_col} + 17'd1;
    assign row_inc  = {1'b0, r_row} + 17'd1;

    always_comb begin
        n_phase    = r_phase;
        n_window   = r_window;
        n_hdr_cnt  = r_hdr_cnt;
        n_fw       = r_fw;
        n_fh       = r_fh;
        n_upscale  = r_upscale;
        n_col      = r_col;
        n_row      = r_row;
        n_low      = r_low;
        n_have_low = r_have_low;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    if (!r_hdr_cnt[2]) begin
                        n_fw = r_fw | hdr_lane;
                    end else begin
                        n_fh = r_fh | hdr_lane;
                    end
                    n_hdr_cnt = r_hdr_cnt + 3'd1;
                    if (r_hdr_cnt == 3'd7) begin
                        // Upscale match uses the raw values, before clamping.
                        n_upscale  = (r_fw == {16'd0, i_upscale_width}) &&
                                     (n_fh == {16'd0, i_upscale_height});
                        n_fw       = (|r_fw[31:16]) ? 32'h0000FFFF : r_fw;
                        n_fh       = (|n_fh[31:16]) ? 32'h0000FFFF : n_fh;
                        n_col      = '0;
                        n_row      = '0;
                        n_have_low = 1'b0;
                        n_low      = '0;
                        o_cmd_push     = 1'b1;
                        o_cmd.is_ready = 1'b1;
                        if (r_fw == 32'd0 || n_fh == 32'd0) begin
                            o_cmd.done = 1'b1;
                            n_phase    = PH_HUNT;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (!r_have_low) begin
                        n_low      = i_rx_byte;
                        n_have_low = 1'b1;
                    end else begin
                        n_have_low    = 1'b0;
                        o_cmd_push    = 1'b1;
                        o_cmd.upscale = r_upscale;
                        o_cmd.row     = r_row;
                        o_cmd.col     = r_col;
                        o_cmd.pix     = {i_rx_byte, r_low};
                        n_col         = col_inc[15:0];
                        if (col_inc >= {1'b0, r_fw[15:0]}) begin
                            n_col = '0;
                            n_row = row_inc[15:0];
                            if (row_inc >= {1'b0, r_fh[15:0]}) begin
                                n_row      = '0;
                                o_cmd.done = 1'b1;
                                n_phase    = PH_HUNT;
                            end
                        end
                    end
                end
                default: begin
                    if (r_window == sifr_pkg::SYNC_PREFIX &&
                        i_rx_byte == sifr_pkg::SYNC_LAST) begin
                        n_window  = '0;
                        n_hdr_cnt = '0;
                        n_fw      = '0;
                        n_fh      = '0;
                        n_phase   = PH_HEADER;
                    end else begin
                        n_window = {r_window[15:0], i_rx_byte};
                        n_phase  = PH_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_window   <= '0;
            r_hdr_cnt  <= '0;
            r_fw       <= '0;
            r_fh       <= '0;
            r_upscale  <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_low      <= '0;
            r_have_low <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_window   <= n_window;
            r_hdr_cnt  <= n_hdr_cnt;
            r_fw       <= n_fw;
            r_fh       <= n_fh;
            r_upscale  <= n_upscale;
            r_col      <= n_col;
            r_row      <= n_row;
            r_low      <= n_low;
            r_have_low <= n_have_low;
        end
    end

endmodule

// ===== rtl/sifr_cmd_fifo.sv =====
// Short command queue between the byte parser and the write sequencer.
module sifr_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sifr_pkg::t_cmd  i_cmd,
    input  logic            i_take,
    output sifr_pkg::t_cmd  o_cmd,
    output logic            o_full,
    output logic            o_empty
);

    sifr_pkg::t_cmd r_mem [sifr_pkg::CMDQ_DEPTH];
    logic [sifr_pkg::CMDQ_AW-1:0] r_wp;
    logic [sifr_pkg::CMDQ_AW-1:0] r_rp;
    logic [sifr_pkg::CMDQ_CW-1:0] r_cnt;

    logic do_push;
    logic do_take;

    assign o_full  = (r_cnt == sifr_pkg::CMDQ_CW'(sifr_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == sifr_pkg::CMDQ_AW'(sifr_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : r_wp + sifr_pkg::CMDQ_AW'(1);
            end
            if (do_take) begin
                r_rp <= (r_rp == sifr_pkg::CMDQ_AW'(sifr_pkg::CMDQ_DEPTH - 1)) ?
                        '0 : r_rp + sifr_pkg::CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + sifr_pkg::CMDQ_CW'(do_push) - sifr_pkg::CMDQ_CW'(do_take);
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sifr_pkg::CMDQ_CW'(sifr_pkg::CMDQ_DEPTH))
        else $error("command queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");
`endif

endmodule

// ===== rtl/sifr_back.sv =====
// Write sequencer: expands commands into results and holds the output register.
module sifr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [11:0]     i_fb_width,
    input  logic [11:0]     i_fb_height,
    input  sifr_pkg::t_cmd  i_cmd,
    input  logic            i_cmd_empty,
    output logic            o_cmd_take,
    input  logic            i_pop,
    output logic            o_empty,
    output logic [1:0]      o_kind,
    output logic [23:0]     o_write_address,
    output logic [15:0]     o_pixel_value,
    output logic            o_last
);

    sifr_pkg::t_cmd r_cmd;
    logic [sifr_pkg::NUM_SLOTS-1:0] r_mask;
    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    logic [23:0] r_out_addr;
    logic [15:0] r_out_pix;
    logic        r_out_last;

    logic [sifr_pkg::NUM_SLOTS-1:0] head_mask;
    logic [sifr_pkg::NUM_SLOTS-1:0] slot_oh;
    logic [sifr_pkg::NUM_SLOTS-1:0] remaining;
    logic        step;
    logic        dr;
    logic        dc;
    logic [16:0] sel_r;
    logic [16:0] sel_c;
    logic [23:0] pix_addr;

    // Coordinate of one replicated write; offsets are 0 or 1 in upscale mode.
    function automatic logic [16:0] coord(input logic [15:0] base, input logic up,
                                          input logic offs);
        logic [16:0] b;
        b = up ? {base, 1'b0} : {1'b0, base};
        return b + {16'd0, offs};
    endfunction

    function automatic logic in_fb(input logic [16:0] r, input logic [16:0] c,
                                   input logic [11:0] fbw, input logic [11:0] fbh);
        return (c < {5'd0, fbw}) && (r < {5'd0, fbh});
    endfunction

    always_comb begin
        head_mask = '0;
        head_mask[sifr_pkg::SLOT_READY] = i_cmd.is_ready;
        head_mask[sifr_pkg::SLOT_W00] = !i_cmd.is_ready &&
            in_fb(coord(i_cmd.row, i_cmd.upscale, 1'b0),
                  coord(i_cmd.col, i_cmd.upscale, 1'b0), i_fb_width, i_fb_height);
        head_mask[sifr_pkg::SLOT_W10] = !i_cmd.is_ready && i_cmd.upscale &&
            in_fb(coord(i_cmd.row, 1'b1, 1'b1),
                  coord(i_cmd.col, 1'b1, 1'b0), i_fb_width, i_fb_height);
        head_mask[sifr_pkg::SLOT_W01] = !i_cmd.is_ready && i_cmd.upscale &&
            in_fb(coord(i_cmd.row, 1'b1, 1'b0),
                  coord(i_cmd.col, 1'b1, 1'b1), i_fb_width, i_fb_height);
        head_mask[sifr_pkg::SLOT_W11] = !i_cmd.is_ready && i_cmd.upscale &&
            in_fb(coord(i_cmd.row, 1'b1, 1'b1),
                  coord(i_cmd.col, 1'b1, 1'b1), i_fb_width, i_fb_height);
        head_mask[sifr_pkg::SLOT_DONE] = i_cmd.done;
    end

    // A new command is loaded only once the current one has nothing left.
    assign o_cmd_take = (r_mask == '0) && !i_cmd_empty;
    assign step       = (r_mask != '0) && (!r_out_valid || i_pop);
    assign slot_oh    = r_mask & (~r_mask + sifr_pkg::NUM_SLOTS'(1));
    assign remaining  = r_mask & ~slot_oh;

    assign dr       = slot_oh[sifr_pkg::SLOT_W10] | slot_oh[sifr_pkg::SLOT_W11];
    assign dc       = slot_oh[sifr_pkg::SLOT_W01] | slot_oh[sifr_pkg::SLOT_W11];
    assign sel_r    = coord(r_cmd.row, r_cmd.upscale, dr);
    assign sel_c    = coord(r_cmd.col, r_cmd.upscale, dc);
    // Surviving writes have both coordinates below 4096, so 12 bits suffice.
    assign pix_addr = {12'd0, sel_r[11:0]} * {12'd0, i_fb_width} + {12'd0, sel_c[11:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_take) begin
                r_mask <= head_mask;
            end else if (step) begin
                r_mask <= remaining;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (step) begin
            r_out_last <= (remaining == '0);
            if (slot_oh[sifr_pkg::SLOT_READY]) begin
                r_out_kind <= sifr_pkg::KIND_READY;
                r_out_addr <= '0;
                r_out_pix  <= '0;
            end else if (slot_oh[sifr_pkg::SLOT_DONE]) begin
                r_out_kind <= sifr_pkg::KIND_DONE;
                r_out_addr <= '0;
                r_out_pix  <= '0;
            end else begin
                r_out_kind <= sifr_pkg::KIND_PIXEL;
                r_out_addr <= pix_addr;
                r_out_pix  <= r_cmd.pix;
            end
        end
    end

    assign o_empty         = !r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_write_address = r_out_addr;
    assign o_pixel_value   = r_out_pix;
    assign o_last          = r_out_last;

`ifndef NO_ASSERTIONS
    a_event_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != sifr_pkg::KIND_PIXEL) |->
        (r_out_addr == '0 && r_out_pix == '0))
        else $error("ready or complete result carries nonzero fields");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == sifr_pkg::KIND_DONE) |-> r_out_last)
        else $error("frame complete result not marked last");
`endif

endmodule

// ===== rtl/serial_image_frame_receiver_unit.sv =====
// Top level of the serial image frame receiver with its configuration registers.
//
// Usage: serial bytes enter on i_rx_byte and are transferred when push is high
// and full is low. Results leave in order: while empty is low the oldest result
// sits on o_kind, o_write_address, o_pixel_value and o_last, and a transfer
// happens when pop is high. o_last marks the final result caused by one byte.
// The parser takes one byte every cycle while its four-entry command queue has
// room; the high byte of a pixel and the last header byte each queue a command.
// The write sequencer loads a command only once the previous one has emitted all
// its results, then emits them in slot order whenever the output register is free
// or popped; a pixel command yields at most one write plain and up to four in
// upscale mode, and the last pixel of a frame also yields frame complete. The first
// result of a byte passes the command queue, command register and output register.
// When the consumer stalls, the output register holds its result, the queue
// fills and full rises; no result is lost. A synchronous reset returns the
// parser to the sync hunt, empties queue and output, and restores the register
// defaults (framebuffer 800x480, upscale size 400x240). The user must write
// registers via the APB-style port only while the block is idle (not enforced).
module serial_image_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [23:0] o_write_address,
    output logic [15:0] o_pixel_value,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [11:0] r_fb_width;
    logic [11:0] r_fb_height;
    logic [15:0] r_upscale_width;
    logic [15:0] r_upscale_height;

    logic           accept;
    logic           cfg_write;
    logic           cmd_push;
    sifr_pkg::t_cmd cmd_in;
    sifr_pkg::t_cmd cmd_head;
    logic           cmd_take;
    logic           cmd_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign accept    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width       <= sifr_pkg::FB_WIDTH_RESET;
            r_fb_height      <= sifr_pkg::FB_HEIGHT_RESET;
            r_upscale_width  <= sifr_pkg::UPSCALE_WIDTH_RESET;
            r_upscale_height <= sifr_pkg::UPSCALE_HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[3:2])
                sifr_pkg::REG_FB_WIDTH:       r_fb_width       <= pwdata[11:0];
                sifr_pkg::REG_FB_HEIGHT:      r_fb_height      <= pwdata[11:0];
                sifr_pkg::REG_UPSCALE_WIDTH:  r_upscale_width  <= pwdata[15:0];
                sifr_pkg::REG_UPSCALE_HEIGHT: r_upscale_height <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            sifr_pkg::REG_FB_WIDTH:       prdata = {20'd0, r_fb_width};
            sifr_pkg::REG_FB_HEIGHT:      prdata = {20'd0, r_fb_height};
            sifr_pkg::REG_UPSCALE_WIDTH:  prdata = {16'd0, r_upscale_width};
            sifr_pkg::REG_UPSCALE_HEIGHT: prdata = {16'd0, r_upscale_height};
            default:                      prdata = '0;
        endcase
    end

    sifr_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_rx_byte        (i_rx_byte),
        .i_upscale_width  (r_upscale_width),
        .i_upscale_height (r_upscale_height),
        .o_cmd_push       (cmd_push),
        .o_cmd            (cmd_in)
    );

    sifr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_take  (cmd_take),
        .o_cmd   (cmd_head),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    sifr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fb_width      (r_fb_width),
        .i_fb_height     (r_fb_height),
        .i_cmd           (cmd_head),
        .i_cmd_empty     (cmd_empty),
        .o_cmd_take      (cmd_take),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_write_address (o_write_address),
        .o_pixel_value   (o_pixel_value),
        .o_last          (o_last)
    );

endmodule

// ===== tb/sv/serial_image_frame_receiver_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the serial image frame receiver unit.
module serial_image_frame_receiver_unit_tb;
    import sifr_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 50;

    typedef enum logic [1:0] {
        SCAN_SYNC   = 2'd0,
        SCAN_HEADER = 2'd1,
        SCAN_PIXELS = 2'd2
    } t_scan_phase;

    typedef struct packed {
        t_kind       kind;
        logic [23:0] addr;
        logic [15:0] pix;
        logic        last;
    } t_frame_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [23:0] o_write_address;
    logic [15:0] o_pixel_value;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    serial_image_frame_receiver_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_rx_byte       (i_rx_byte),
        .empty           (empty),
        .pop             (pop),
        .o_kind          (o_kind),
        .o_write_address (o_write_address),
        .o_pixel_value   (o_pixel_value),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Register copies, starting from the reset defaults.
    logic [11:0] cfg_fb_w = FB_WIDTH_RESET;
    logic [11:0] cfg_fb_h = FB_HEIGHT_RESET;
    logic [15:0] cfg_up_w = UPSCALE_WIDTH_RESET;
    logic [15:0] cfg_up_h = UPSCALE_HEIGHT_RESET;

    // Parser state of the prediction.
    t_scan_phase scan_phase = SCAN_SYNC;
    logic [23:0] sync_win   = '0;
    int unsigned hdr_count  = 0;
    logic [31:0] frm_w      = '0;
    logic [31:0] frm_h      = '0;
    bit          up_on      = 1'b0;
    bit          have_low   = 1'b0;
    logic [7:0]  low_b      = '0;
    int unsigned col        = 0;
    int unsigned row        = 0;

    t_frame_event expected_events[$];
    logic [7:0]   rx_bytes[$];

    bit rx_taken      = 1'b0;
    int burst_left    = 1;
    int gap_left      = 0;
    int pop_mode      = 0;
    int pop_span      = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int bytes_fed     = 0;
    int results_checked = 0;
    int frames_seen   = 0;
    int upscaled_frames = 0;
    int settings_used = 0;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < MAX_REPORTS)
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic push_event(input t_kind kind, input logic [23:0] addr,
                              input logic [15:0] pix);
        t_frame_event ev;
        ev.kind = kind;
        ev.addr = addr;
        ev.pix  = pix;
        ev.last = 1'b0;
        expected_events.push_back(ev);
    endtask

    // Writes outside the framebuffer are dropped.
    task automatic emit_write(input int unsigned r, input int unsigned c, input logic [15:0] px);
        int unsigned addr;
        if (c < 32'(cfg_fb_w) && r < 32'(cfg_fb_h)) begin
            addr = r * 32'(cfg_fb_w) + c;
            push_event(KIND_PIXEL, addr[23:0], px);
        end
    endtask

    // Advances the parser by one received byte and queues the results it causes.
    task automatic parse_rx_byte(input logic [7:0] b);
        int          first;
        logic [15:0] px;
        t_frame_event ev;
        first = expected_events.size();
        case (scan_phase)
            SCAN_HEADER: begin
                if (hdr_count < 4)
                    frm_w = frm_w | (32'(b) << (8 * (hdr_count % 4)));
                else
                    frm_h = frm_h | (32'(b) << (8 * (hdr_count % 4)));
                hdr_count = (hdr_count + 1) % 8;
                if (hdr_count == 0) begin
                    // The upscale match sees the raw header values, before the clamp.
                    up_on = (frm_w == 32'(cfg_up_w)) && (frm_h == 32'(cfg_up_h));
                    if (frm_w > 32'd65535) frm_w = 32'd65535;
                    if (frm_h > 32'd65535) frm_h = 32'd65535;
                    col = 0;
                    row = 0;
                    have_low = 1'b0;
                    low_b = '0;
                    frames_seen++;
                    push_event(KIND_READY, '0, '0);
                    if (frm_w == 0 || frm_h == 0) begin
                        push_event(KIND_DONE, '0, '0);
                        scan_phase = SCAN_SYNC;
                    end else begin
                        if (up_on) upscaled_frames++;
                        scan_phase = SCAN_PIXELS;
                    end
                end
            end
            SCAN_PIXELS: begin
                if (!have_low) begin
                    low_b = b;
                    have_low = 1'b1;
                end else begin
                    px = {b, low_b};
                    have_low = 1'b0;
                    if (up_on) begin
                        emit_write(2 * row, 2 * col, px);
                        emit_write(2 * row + 1, 2 * col, px);
                        emit_write(2 * row, 2 * col + 1, px);
                        emit_write(2 * row + 1, 2 * col + 1, px);
                    end else begin
                        emit_write(row, col, px);
                    end
                    col++;
                    if (col >= frm_w) begin
                        col = 0;
                        row++;
                        if (row >= frm_h) begin
                            row = 0;
                            push_event(KIND_DONE, '0, '0);
                            scan_phase = SCAN_SYNC;
                        end
                    end
                end
            end
            default: begin
                if (sync_win == SYNC_PREFIX && b == SYNC_LAST) begin
                    sync_win = '0;
                    hdr_count = 0;
                    frm_w = '0;
                    frm_h = '0;
                    scan_phase = SCAN_HEADER;
                end else begin
                    sync_win = {sync_win[15:0], b};
                end
            end
        endcase
        if (expected_events.size() > first) begin
            ev = expected_events.pop_back();
            ev.last = 1'b1;
            expected_events.push_back(ev);
        end
    endtask

    // Byte sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin : drive_bytes
        logic       next_push;
        logic [7:0] next_byte;
        next_push = push;
        next_byte = i_rx_byte;
        if (!push || rx_taken) begin
            next_push = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (rx_bytes.size() > 0) begin
                next_push = 1'b1;
                next_byte = rx_bytes.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
        end
        push <= next_push;
        i_rx_byte <= next_byte;
    end

    // Result receiver: free-running, random, or sparse pops in stretches of random length.
    always @(negedge i_clk) begin : drive_pop
        logic next_pop;
        if (pop_span == 0) begin
            pop_mode = $urandom_range(0, 2);
            pop_span = $urandom_range(20, 200);
        end
        pop_span--;
        case (pop_mode)
            0: next_pop = 1'b1;
            1: next_pop = $urandom_range(0, 1);
            default: next_pop = ($urandom_range(0, 7) == 0);
        endcase
        pop <= next_pop;
    end

    always @(posedge i_clk) begin : watch_ports
        t_frame_event want;
        t_frame_event got;
        rx_taken = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                rx_taken = 1'b1;
                bytes_fed++;
                parse_rx_byte(i_rx_byte);
            end
            if (pop && !empty) begin
                got.kind = t_kind'(o_kind);
                got.addr = o_write_address;
                got.pix  = o_pixel_value;
                got.last = o_last;
                if (expected_events.size() == 0) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"%0t: unexpected result, expected none, ",
                                  "actual kind %0d addr 0x%0h pix 0x%0h last %0b"},
                                 $time, got.kind, got.addr, got.pix, got.last);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    results_checked++;
                    if (got.kind !== want.kind)
                        report_mismatch("kind", want.kind, got.kind);
                    if (got.addr !== want.addr)
                        report_mismatch("write_address", want.addr, got.addr);
                    if (got.pix !== want.pix)
                        report_mismatch("pixel_value", want.pix, got.pix);
                    if (got.last !== want.last)
                        report_mismatch("last", want.last, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_events.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic apb_access(input bit write, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        case (idx)
            REG_FB_WIDTH:       return 32'(cfg_fb_w);
            REG_FB_HEIGHT:      return 32'(cfg_fb_h);
            REG_UPSCALE_WIDTH:  return 32'(cfg_up_w);
            REG_UPSCALE_HEIGHT: return 32'(cfg_up_h);
            default:            return '0;
        endcase
    endfunction

    task automatic verify_register(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, '0, rd);
        if (rd !== register_value(idx))
            report_mismatch("register read", register_value(idx), rd);
    endtask

    task automatic set_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        apb_access(1'b1, idx, val, rd);
        case (idx)
            REG_FB_WIDTH:       cfg_fb_w = val[11:0];
            REG_FB_HEIGHT:      cfg_fb_h = val[11:0];
            REG_UPSCALE_WIDTH:  cfg_up_w = val[15:0];
            REG_UPSCALE_HEIGHT: cfg_up_h = val[15:0];
            default: ;
        endcase
        verify_register(idx);
    endtask

    task automatic apply_setting(input logic [31:0] fbw, input logic [31:0] fbh,
                                 input logic [31:0] upw, input logic [31:0] uph);
        set_register(REG_FB_WIDTH, fbw);
        set_register(REG_FB_HEIGHT, fbh);
        set_register(REG_UPSCALE_WIDTH, upw);
        set_register(REG_UPSCALE_HEIGHT, uph);
        settings_used++;
    endtask

    // Lets every queued byte go through and every result drain, plus a settling margin.
    task automatic wait_idle();
        @(negedge i_clk);
        while (rx_bytes.size() != 0 || push || expected_events.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_sync();
        rx_bytes.push_back(SYNC_PREFIX[23:16]);
        rx_bytes.push_back(SYNC_PREFIX[15:8]);
        rx_bytes.push_back(SYNC_PREFIX[7:0]);
        rx_bytes.push_back(SYNC_LAST);
    endtask

    task automatic queue_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) rx_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic queue_pixel(input logic [15:0] px);
        rx_bytes.push_back(px[7:0]);
        rx_bytes.push_back(px[15:8]);
    endtask

    // A complete frame: sync word, header and random pixel payload.
    task automatic queue_frame(input logic [31:0] w, input logic [31:0] h);
        longint npix;
        npix = longint'((w > 32'd65535) ? 32'd65535 : w) *
               longint'((h > 32'd65535) ? 32'd65535 : h);
        queue_sync();
        queue_word(w);
        queue_word(h);
        for (longint i = 0; i < npix; i++) queue_pixel(16'($urandom));
    endtask

    // Noise that never completes a sync word, each followed by a well-formed frame, until target bytes are queued.
    task automatic queue_random_frames(input int target);
        int          start;
        int          pick;
        logic [7:0]  nb;
        logic [31:0] w;
        logic [31:0] h;
        start = rx_bytes.size();
        while (rx_bytes.size() - start < target) begin
            if ($urandom_range(0, 4) == 0) begin
                rx_bytes.push_back(SYNC_PREFIX[23:16]);
                rx_bytes.push_back(SYNC_PREFIX[15:8]);
                rx_bytes.push_back(SYNC_PREFIX[7:0]);
            end
            repeat ($urandom_range(0, 3)) begin
                nb = $urandom_range(0, 255);
                if (nb == SYNC_LAST) nb = nb ^ 8'h80;
                rx_bytes.push_back(nb);
            end
            pick = $urandom_range(0, 9);
            if (pick < 3 && cfg_up_w <= 16'd6 && cfg_up_h <= 16'd6) begin
                w = 32'(cfg_up_w);
                h = 32'(cfg_up_h);
            end else if (pick == 3) begin
                w = $urandom;
                h = $urandom;
                if ($urandom_range(0, 1) == 0) w = '0;
                else h = '0;
            end else begin
                w = $urandom_range(1, 4);
                h = $urandom_range(1, 3);
            end
            queue_frame(w, h);
        end
    endtask

    initial begin : stimulus
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        verify_register(REG_FB_WIDTH);
        verify_register(REG_FB_HEIGHT);
        verify_register(REG_UPSCALE_WIDTH);
        verify_register(REG_UPSCALE_HEIGHT);

        // Directed: a false start of the sync word, a 2x1 frame with extreme pixels,
        // and an empty frame whose width needs clamping.
        rx_bytes.push_back(8'h00);
        rx_bytes.push_back(SYNC_PREFIX[23:16]);
        rx_bytes.push_back(SYNC_PREFIX[7:0]);
        queue_sync();
        queue_word(32'd2);
        queue_word(32'd1);
        queue_pixel(16'hFFFF);
        queue_pixel(16'h0000);
        queue_sync();
        queue_word(32'hFFFF_FFFF);
        queue_word(32'd0);
        wait_idle();

        // Replicated frames partly fall outside a small framebuffer.
        apply_setting(32'd5, 32'd3, 32'd3, 32'd2);
        queue_random_frames(20);
        wait_idle();
        apply_setting(32'd1, 32'd1, 32'd0, 32'd0);
        queue_random_frames(20);
        wait_idle();
        apply_setting(32'd4095, 32'd4095, 32'd2, 32'd2);
        queue_random_frames(20);
        wait_idle();
        // A zero width or height register suppresses every write.
        apply_setting(32'd0, 32'd4095, 32'd65535, 32'd65535);
        queue_random_frames(20);
        wait_idle();
        apply_setting(32'd7, 32'd0, 32'd1, 32'd3);
        queue_random_frames(20);
        wait_idle();

        // A width above 65535 runs as 65535 columns and must not match a 1x1 upscale
        // size through truncation; the first few pixels of that frame end the run.
        apply_setting(32'd3, 32'd2, 32'd1, 32'd1);
        queue_sync();
        queue_word(32'h0001_0001);
        queue_word(32'd1);
        repeat (5) queue_pixel(16'($urandom));
        wait_idle();

        if (expected_events.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_events.size());
            mismatch_count++;
        end
        $display("Fed %0d serial bytes holding %0d frame headers (%0d replicated frames)",
                 bytes_fed, frames_seen, upscaled_frames);
        $display("under %0d register settings; checked %0d results, %0d mismatches.",
                 settings_used + 1, results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
